// ----- src/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define RGBHSV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence that must follow a trigger after a fixed number of edges
`define RGBHSV_ASSERT_AFTER(label, clk, rst, trig, n, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##n (prop)) \
      else $error(msg);

`endif

// ----- src/rgbhsv_pkg.sv -----
// types, constants and latency helpers for the rgb to hsv converter
// no dependencies
`default_nettype none

package rgbhsv_pkg;

   localparam int unsigned CHAN_W            = 8;
   localparam int unsigned FIELD_W           = 15;
   localparam int unsigned HUE_FRAC_BITS_DEF = 6;
   // hue numerator 60*sixths, wrapped positive, stays below 360*255
   localparam int unsigned NUM_W             = 17;
   // saturation dividend 25600*delta
   localparam int unsigned SAT_DVD_W         = 23;
   // quotient bits resolved per divider stage
   localparam int unsigned DIV_STEPS         = 4;
   localparam int unsigned FRONT_STAGES      = 2;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [FIELD_W-1:0] hue;
      logic [FIELD_W-1:0] saturation;
      logic [FIELD_W-1:0] brightness;
   } hsv_type;

   typedef struct packed {
      logic                 valid;
      logic                 grey;
      logic [NUM_W-1:0]     hue_num;
      logic [CHAN_W-1:0]    delta;
      logic [CHAN_W-1:0]    max_chan;
      logic [SAT_DVD_W-1:0] sat_dvd;
      logic [FIELD_W-1:0]   brightness;
   } front_type;

   typedef struct packed {
      logic               valid;
      logic               grey;
      logic [FIELD_W-1:0] brightness;
   } side_type;

   // dividend width shared by both dividers so that they line up
   function automatic int unsigned div_width(input int unsigned hue_frac);
      int unsigned hue_w;
      hue_w = NUM_W + hue_frac;
      return (hue_w > SAT_DVD_W) ? hue_w : SAT_DVD_W;
   endfunction

   function automatic int unsigned div_stages(input int unsigned hue_frac);
      return (div_width(hue_frac) + DIV_STEPS - 1) / DIV_STEPS;
   endfunction

   // edges from the accepting edge to the edge that takes the result
   function automatic int unsigned latency(input int unsigned hue_frac);
      return FRONT_STAGES + div_stages(hue_frac) + 1;
   endfunction

endpackage

`default_nettype wire

// ----- src/rgbhsv_front.sv -----
// first two pipeline stages: max/min search, hue numerator, dividends, brightness
// depends on rgbhsv_pkg
`default_nettype none

module rgbhsv_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire rgbhsv_pkg::pixel_type pixel,
   output rgbhsv_pkg::front_type      front
);

   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } max_sel_type;

   localparam int unsigned CW = rgbhsv_pkg::CHAN_W;
   localparam int unsigned FW = rgbhsv_pkg::FIELD_W;
   localparam int unsigned NW = rgbhsv_pkg::NUM_W;
   localparam int unsigned SW = rgbhsv_pkg::SAT_DVD_W;

   // stage one
   logic                 valid1_ff, valid1_in;
   logic [CW-1:0]        max_ff, max_in;
   logic [CW-1:0]        delta_ff, delta_in;
   logic signed [CW:0]   diff_ff, diff_in;
   max_sel_type          sel_ff, sel_in;

   // stage two
   rgbhsv_pkg::front_type out_ff, out_in;

   always_comb begin
      logic [CW-1:0] mn;
      valid1_in = in_valid;
      if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
         sel_in = SEL_RED;
         max_in = pixel.red;
         diff_in = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
      end else if (pixel.green >= pixel.blue) begin
         sel_in = SEL_GREEN;
         max_in = pixel.green;
         diff_in = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
      end else begin
         sel_in = SEL_BLUE;
         max_in = pixel.blue;
         diff_in = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
      end
      mn = pixel.red;
      if (pixel.green < mn) mn = pixel.green;
      if (pixel.blue < mn) mn = pixel.blue;
      delta_in = max_in - mn;
   end

   always_comb begin
      logic [CW+1:0]        base;
      logic signed [CW+3:0] sixths;
      logic signed [NW+1:0] num;
      logic [NW-1:0]        wrap;
      logic [FW-1:0]        y;
      logic [FW:0]          frac;
      // hue / 60 = sixths / delta, sixths up to five times delta
      case (sel_ff)
         SEL_RED:   base = '0;
         SEL_GREEN: base = {1'b0, delta_ff, 1'b0};
         SEL_BLUE:  base = {delta_ff, 2'b00};
         default:   base = '0;
      endcase
      sixths = $signed({2'b00, base}) + $signed({{3{diff_ff[CW]}}, diff_ff});
      num    = (NW+2)'(sixths) * $signed((NW+2)'(60));
      wrap   = NW'(delta_ff) * NW'(360);
      if (num < 0) num = num + $signed({2'b00, wrap});
      // 25600*max/255 = 100*max + 100*max/255
      y    = FW'(max_ff) * FW'(100);
      frac = ({1'b0, y} + (FW+1)'(y >> 8) + (FW+1)'(1)) >> 8;

      out_in.valid      = valid1_ff;
      out_in.grey       = (delta_ff == '0);
      out_in.hue_num    = num[NW-1:0];
      out_in.delta      = delta_ff;
      out_in.max_chan   = max_ff;
      out_in.sat_dvd    = SW'(delta_ff) * SW'(25600);
      out_in.brightness = y + frac[FW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff    <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         valid1_ff    <= valid1_in;
         out_ff.valid <= out_in.valid;
      end
      max_ff            <= max_in;
      delta_ff          <= delta_in;
      diff_ff           <= diff_in;
      sel_ff            <= sel_in;
      out_ff.grey       <= out_in.grey;
      out_ff.hue_num    <= out_in.hue_num;
      out_ff.delta      <= out_in.delta;
      out_ff.max_chan   <= out_in.max_chan;
      out_ff.sat_dvd    <= out_in.sat_dvd;
      out_ff.brightness <= out_in.brightness;
   end

   assign front = out_ff;

endmodule

`default_nettype wire

// ----- src/rgbhsv_div.sv -----
// pipelined restoring divider, a few quotient bits per register stage
// no dependencies
`default_nettype none

module rgbhsv_div #(
   parameter int unsigned DIVIDEND_W = 23,
   parameter int unsigned DIVISOR_W  = 8,
   parameter int unsigned STEPS      = 4
) (
   input  wire logic                  clock,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic      [DIVIDEND_W-1:0] quotient
);

   localparam int unsigned STAGES = (DIVIDEND_W + STEPS - 1) / STEPS;
   localparam int unsigned ACC_W  = DIVISOR_W + DIVIDEND_W;

   // upper part partial remainder, lower part dividend bits out / quotient bits in
   logic [ACC_W-1:0]     acc_ff [STAGES];
   logic [ACC_W-1:0]     acc_in [STAGES];
   logic [DIVISOR_W-1:0] dvs_ff [STAGES];
   logic [DIVISOR_W-1:0] dvs_in [STAGES];

   function automatic logic [ACC_W-1:0] stage_step(
      input logic [ACC_W-1:0]     acc_i,
      input logic [DIVISOR_W-1:0] dvs,
      input int unsigned          first
   );
      logic [ACC_W-1:0]   acc;
      logic [DIVISOR_W:0] part;
      logic               qbit;
      acc  = acc_i;
      part = '0;
      qbit = 1'b0;
      for (int unsigned k = 0; k < STEPS; k++) begin
         if (first + k < DIVIDEND_W) begin
            part = acc[ACC_W-1 -: DIVISOR_W+1];
            qbit = (part >= {1'b0, dvs});
            if (qbit) part = part - {1'b0, dvs};
            acc = {part[DIVISOR_W-1:0], acc[DIVIDEND_W-2:0], qbit};
         end
      end
      return acc;
   endfunction

   always_comb begin
      acc_in[0] = stage_step(ACC_W'(dividend), divisor, 0);
      dvs_in[0] = divisor;
      for (int unsigned s = 1; s < STAGES; s++) begin
         acc_in[s] = stage_step(acc_ff[s-1], dvs_ff[s-1], s * STEPS);
         dvs_in[s] = dvs_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = acc_ff[STAGES-1][DIVIDEND_W-1:0];

endmodule

`default_nettype wire

// ----- src/rgb_to_hsv_converter.sv -----
// top level of the rgb to hsv converter: front stages, two dividers, output register
// depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_div
`default_nettype none

// usage
//   input: a transaction is taken at each rising edge with start high and busy
//   low; req_pixel holds the 8-bit red, green and blue channels
//   busy is held low, so a new pixel may enter at every clock
//   output: rsp_valid is high for exactly one cycle per pixel, with rsp_hsv
//   holding hue (degrees, HUE_FRAC_BITS fraction bits), saturation and
//   brightness (percent, 8 fraction bits) during that cycle
//   path: each pixel passes through the front stages, the dividers and the output register
//   throughput: one pixel per clock; the depth is set by the two pipelined
//   restoring dividers, which resolve four quotient bits per stage
//   results leave in the order the pixels came in
//   reset clears every valid bit, so pixels in flight are dropped and no
//   result shows after reset until new pixels arrive
//   the receiver cannot stall: results are never held back
module rgb_to_hsv_converter #(
   parameter int unsigned HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire rgbhsv_pkg::pixel_type req_pixel,
   output logic                       rsp_valid,
   output rgbhsv_pkg::hsv_type        rsp_hsv
);

   localparam int unsigned DIV_W      = rgbhsv_pkg::div_width(HUE_FRAC_BITS);
   localparam int unsigned DIV_STAGES = rgbhsv_pkg::div_stages(HUE_FRAC_BITS);
   localparam int unsigned CW         = rgbhsv_pkg::CHAN_W;
   localparam int unsigned FW         = rgbhsv_pkg::FIELD_W;

   rgbhsv_pkg::front_type front;
   logic [DIV_W-1:0]      hue_dvd;
   logic [DIV_W-1:0]      sat_dvd;
   logic [DIV_W-1:0]      hue_q;
   logic [DIV_W-1:0]      sat_q;

   // grey flag and brightness ride alongside the dividers
   rgbhsv_pkg::side_type  side_ff [DIV_STAGES];
   rgbhsv_pkg::side_type  side_in [DIV_STAGES];
   rgbhsv_pkg::side_type  side_last;

   logic                  rsp_valid_ff, rsp_valid_in;
   rgbhsv_pkg::hsv_type   rsp_hsv_ff, rsp_hsv_in;

   // pipeline never stalls, so a transaction can always be taken
   assign busy = 1'b0;

   // max/min, hue numerator, saturation dividend and brightness
   rgbhsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .pixel    (req_pixel),
      .front    (front)
   );

   // hue = numerator * 2^frac / delta
   assign hue_dvd = DIV_W'(front.hue_num) << HUE_FRAC_BITS;
   // saturation = 25600 * delta / max
   assign sat_dvd = DIV_W'(front.sat_dvd);

   rgbhsv_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (CW),
      .STEPS      (rgbhsv_pkg::DIV_STEPS)
   ) u_hue_div (
      .clock    (clock),
      .dividend (hue_dvd),
      .divisor  (front.delta),
      .quotient (hue_q)
   );

   rgbhsv_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (CW),
      .STEPS      (rgbhsv_pkg::DIV_STEPS)
   ) u_sat_div (
      .clock    (clock),
      .dividend (sat_dvd),
      .divisor  (front.max_chan),
      .quotient (sat_q)
   );

   // side line matched to divider depth
   always_comb begin
      side_in[0].valid      = front.valid;
      side_in[0].grey       = front.grey;
      side_in[0].brightness = front.brightness;
      for (int unsigned s = 1; s < DIV_STAGES; s++) begin
         side_in[s] = side_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int unsigned s = 0; s < DIV_STAGES; s++) begin
            side_ff[s] <= '0;
         end
      end else begin
         side_ff <= side_in;
      end
   end

   assign side_last = side_ff[DIV_STAGES-1];

   // output register; grey pixels force hue and saturation to zero
   always_comb begin
      rsp_valid_in          = side_last.valid;
      rsp_hsv_in.hue        = side_last.grey ? '0 : hue_q[FW-1:0];
      rsp_hsv_in.saturation = side_last.grey ? '0 : sat_q[FW-1:0];
      rsp_hsv_in.brightness = side_last.brightness;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hsv_ff <= rsp_hsv_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hsv   = rsp_hsv_ff;

endmodule

`default_nettype wire

// ----- src/rgbhsv_checker.sv -----
// port-level checker for the rgb to hsv converter, with its bind
// depends on rgbhsv_pkg, assert_macros.svh, rgb_to_hsv_converter
`default_nettype none

`include "assert_macros.svh"

module rgbhsv_checker #(
   parameter int unsigned HUE_FRAC_BITS = rgbhsv_pkg::HUE_FRAC_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire rgbhsv_pkg::pixel_type req_pixel,
   input wire logic                  rsp_valid,
   input wire rgbhsv_pkg::hsv_type   rsp_hsv
);

   localparam int unsigned LAT = rgbhsv_pkg::latency(HUE_FRAC_BITS);

   logic taken;
   logic grey_px;

   assign taken   = start && !busy;
   assign grey_px = (req_pixel.red == req_pixel.green) && (req_pixel.green == req_pixel.blue);

   // every taken pixel gives a result after the fixed latency
   `RGBHSV_ASSERT_AFTER(a_result_follows, clock, reset, taken, LAT, rsp_valid, "result missing")

   // no result without a pixel taken the fixed latency earlier
   `RGBHSV_ASSERT(a_no_phantom, clock, reset, !rsp_valid || $past(taken, LAT), "stray result")

   // grey pixel gives zero hue and zero saturation
   `RGBHSV_ASSERT_AFTER(a_grey_zero, clock, reset, taken && grey_px, LAT, (rsp_hsv.hue == '0) && (rsp_hsv.saturation == '0), "grey pixel not zero")

   // percentages never pass one hundred
   `RGBHSV_ASSERT(a_percent_range, clock, reset, !rsp_valid || ((rsp_hsv.saturation <= 15'd25600) && (rsp_hsv.brightness <= 15'd25600)), "percent out of range")

endmodule

bind rgb_to_hsv_converter rgbhsv_checker #(
   .HUE_FRAC_BITS (HUE_FRAC_BITS)
) u_rgbhsv_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_pixel (req_pixel),
   .rsp_valid (rsp_valid),
   .rsp_hsv   (rsp_hsv)
);

`default_nettype wire

// ----- verif/tb_rgb_to_hsv_converter.sv -----
// self-checking testbench for rgb_to_hsv_converter: corner pixels, then random pixels
// under several sender idling patterns, each result checked against a behavioural predictor
// depends on rgbhsv_pkg and the rgb_to_hsv_converter rtl
`timescale 1ns / 1ps

// keeps the hsv values still owed by the converter, oldest first
class hsv_tracker;
   int unsigned               hue_frac;
   rgbhsv_pkg::hsv_type       hsv_owed[$];
   int unsigned               fails;

   function new(int unsigned frac);
      hue_frac = frac;
      fails    = 0;
   endfunction

   // exact hsv of one pixel, every quotient truncated towards zero
   function rgbhsv_pkg::hsv_type convert_pixel(rgbhsv_pkg::pixel_type p);
      longint              r, g, b, hi, lo, delta, sixths, num, wide;
      rgbhsv_pkg::hsv_type h;
      r  = p.red;
      g  = p.green;
      b  = p.blue;
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      wide  = (hi * 25600) / 255;
      h.brightness = wide[rgbhsv_pkg::FIELD_W-1:0];
      h.saturation = '0;
      h.hue        = '0;
      if (delta > 0) begin
         wide = (delta * 25600) / hi;
         h.saturation = wide[rgbhsv_pkg::FIELD_W-1:0];
         // ties go to red first, then green
         if (r >= hi)
            sixths = g - b;
         else if (g >= hi)
            sixths = 2 * delta + (b - r);
         else
            sixths = 4 * delta + (r - g);
         num = sixths * 60;
         if (num < 0) num += 360 * delta;
         wide  = (num << hue_frac) / delta;
         h.hue = wide[rgbhsv_pkg::FIELD_W-1:0];
      end
      return h;
   endfunction

   function void note_pixel(rgbhsv_pkg::pixel_type p);
      hsv_owed.push_back(convert_pixel(p));
   endfunction

   function void check_hsv(rgbhsv_pkg::hsv_type got);
      rgbhsv_pkg::hsv_type want;
      if (hsv_owed.size() == 0) begin
         $error("unexpected result: hue %0d saturation %0d brightness %0d",
                got.hue, got.saturation, got.brightness);
         fails++;
         return;
      end
      want = hsv_owed.pop_front();
      if (got.hue !== want.hue) begin
         $error("hue mismatch: expected %0d, got %0d", want.hue, got.hue);
         fails++;
      end
      if (got.saturation !== want.saturation) begin
         $error("saturation mismatch: expected %0d, got %0d", want.saturation, got.saturation);
         fails++;
      end
      if (got.brightness !== want.brightness) begin
         $error("brightness mismatch: expected %0d, got %0d", want.brightness, got.brightness);
         fails++;
      end
   endfunction

   function int unsigned outstanding();
      return hsv_owed.size();
   endfunction
endclass

module tb_rgb_to_hsv_converter;

   localparam int unsigned HUE_FRAC       = rgbhsv_pkg::HUE_FRAC_BITS_DEF;
   // edges from the taking edge to the edge that takes the result
   localparam int unsigned PIPE_LATENCY   = rgbhsv_pkg::latency(HUE_FRAC);
   // cycles with no transaction on either side before the run is abandoned
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_PIXELS   = 358;
   localparam int unsigned N_PHASES       = 4;
   localparam int unsigned N_CORNERS      = 21;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   rgbhsv_pkg::pixel_type req_pixel = '0;
   logic                  rsp_valid;
   rgbhsv_pkg::hsv_type   rsp_hsv;

   hsv_tracker  sb = new(HUE_FRAC);
   int unsigned quiet_cycles = 0;

   // sender idle percentage per random phase: flat out, heavy idling, light idling, heavy again
   int unsigned idle_pct [N_PHASES] = '{0, 59, 27, 59};

   // hand-picked pixels: black, white, greys, the primaries and secondaries (ties for the
   // maximum), a red-dominant pixel whose hue wraps below zero, each channel as maximum,
   // one-step deltas and near-white pixels
   rgbhsv_pkg::pixel_type corner_pixels [N_CORNERS] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hC80A64, 24'h0AC864, 24'h0A64C8,
      24'h010000, 24'hFFFEFE, 24'h55AAFF, 24'hFE0180, 24'h010100, 24'hFFFFFE, 24'h7F807F
   };

   rgb_to_hsv_converter #(
      .HUE_FRAC_BITS(HUE_FRAC)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_hsv   (rsp_hsv)
   );

   always #10 clock = ~clock;

   // monitor: outputs sampled at the rising edge, before the edge's own updates land
   always @(posedge clock) begin
      if (!reset) begin
         // a result at this edge always belongs to an older transaction
         if (rsp_valid) sb.check_hsv(rsp_hsv);
         if (start && !busy) sb.note_pixel(req_pixel);
      end
   end

   // watchdog: any transaction on either side resets the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("rgb_to_hsv_converter test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one pixel from the falling edge and hold it until it is taken
   task automatic drive_pixel(input rgbhsv_pkg::pixel_type p);
      @(negedge clock);
      start     <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (busy);
   endtask

   // one idle cycle, with junk on the data lines so that only start qualifies them
   task automatic idle_cycle();
      @(negedge clock);
      start     <= 1'b0;
      req_pixel <= rgbhsv_pkg::pixel_type'($urandom_range(24'hFFFFFF));
   endtask

   // hold the sender off until every owed result has come back
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // random pixel, weighted towards the awkward regions of the colour space
   function automatic rgbhsv_pkg::pixel_type random_pixel();
      rgbhsv_pkg::pixel_type p;
      int unsigned           kind, top, low, base, pick;
      kind = $urandom_range(99);
      p    = rgbhsv_pkg::pixel_type'($urandom_range(24'hFFFFFF));
      if (kind < 60) begin
         // uniform over the whole cube
      end else if (kind < 70) begin
         // grey: all channels equal
         base = $urandom_range(255);
         p    = '{base[7:0], base[7:0], base[7:0]};
      end else if (kind < 82) begin
         // two channels tie for the maximum, the third at or below them
         top  = $urandom_range(255);
         low  = $urandom_range(top);
         pick = $urandom_range(2);
         case (pick)
            0: p = '{top[7:0], top[7:0], low[7:0]};
            1: p = '{low[7:0], top[7:0], top[7:0]};
            default: p = '{top[7:0], low[7:0], top[7:0]};
         endcase
      end else if (kind < 92) begin
         // tiny spread around a random level: delta of at most 2
         base    = $urandom_range(253);
         p.red   = 8'(base + $urandom_range(2));
         p.green = 8'(base + $urandom_range(2));
         p.blue  = 8'(base + $urandom_range(2));
      end else begin
         // channels pinned to the rails
         if ($urandom_range(1)) p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
         if ($urandom_range(1)) p.green = $urandom_range(1) ? 8'hFF : 8'h00;
         if ($urandom_range(1)) p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      return p;
   endfunction

   initial begin
      // synchronous reset, released on a falling edge
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // corner pixels back to back
      foreach (corner_pixels[i]) drive_pixel(corner_pixels[i]);
      wait_drained();

      // random phases, each ending with the sender waiting for a full drain
      for (int ph = 0; ph < N_PHASES; ph++) begin
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            while ($urandom_range(99) < idle_pct[ph]) idle_cycle();
            drive_pixel(random_pixel());
         end
         wait_drained();
      end

      // let anything stray fall out of the pipeline before judging
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d results never arrived", sb.outstanding());
         sb.fails++;
      end

      if (sb.fails == 0)
         $display("rgb_to_hsv_converter test passed");
      else
         $display("rgb_to_hsv_converter test failed");
      $finish;
   end

endmodule
